[hdl/fplog_pkg.sv]
package fplog_pkg;

  // Internal magnitudes are unsigned Q2.30.
  localparam int QB  = 30;
  // Width of the signed log value before scaling; holds e*ln2 for exponent magnitudes up to 738.
  localparam int LNW = 40;
  // Quotient bits resolved per divider stage, and the number of such stages.
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = QB / DIV_STEP;

  localparam logic [31:0] Q_TWO    = 32'd2147483648;
  localparam logic [31:0] Q_TWO_3  = 32'd715827883;
  localparam logic [31:0] Q_TWO_5  = 32'd429496730;
  localparam logic [31:0] Q_TWO_7  = 32'd306783378;
  localparam logic [31:0] Q_LN2    = 32'd744261117;
  localparam logic [31:0] Q_LOG10E = 32'd466320147;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DOMAIN = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  // Per-word data that rides along the pipeline next to the arithmetic.
  typedef struct packed {
    logic                   ten;
    logic                   spec;
    status_t                status;
    logic signed [LNW-1:0]  eln;
  } side_t;

  // Shift a product back to Q2.30, rounding to nearest with ties up.
  function automatic logic [LNW-1:0] q30_rnd(input logic [71:0] prod);
    logic [71:0] s;
    s = prod + (72'd1 << (QB - 1));
    return s[QB+LNW-1:QB];
  endfunction

endpackage

[hdl/fplog_ifs.sv]
interface fplog_in_if #(parameter int WIDTH = 32);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;
  logic             base_ten;
  modport source (output valid, value, base_ten, input ready);
  modport sink (input valid, value, base_ten, output ready);
endinterface

interface fplog_out_if #(parameter int WIDTH = 32);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result;
  logic [1:0]       status;
  modport source (output valid, result, status, input ready);
  modport sink (input valid, result, status, output ready);
endinterface

[hdl/fplog_norm.sv]
module fplog_norm #(
  parameter int WIDTH     = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [WIDTH-1:0]     value,
  input  logic                 ten,
  output logic                 out_vld,
  output logic [fplog_pkg::QB:0] m,
  output fplog_pkg::side_t     side
);

  localparam int PW = $clog2(WIDTH);

  logic             a_vld, b_vld;
  logic [WIDTH-1:0] a_x, b_x;
  logic             a_ten, b_ten;
  logic             a_spec, b_spec;
  fplog_pkg::status_t a_st, b_st;
  logic [PW-1:0]    p_next, b_p;
  logic [WIDTH+fplog_pkg::QB-1:0] shifted;
  logic signed [PW+1:0] e;
  logic signed [fplog_pkg::LNW-1:0] eln;
  fplog_pkg::side_t side_next;

  // Position of the leading one.
  always_comb begin
    p_next = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (a_x[i]) p_next = PW'(i);
    end
  end

  assign shifted = {b_x, {fplog_pkg::QB{1'b0}}} >> b_p;
  assign e = $signed({2'b00, b_p}) - $signed((PW+2)'(FRAC_BITS));
  assign eln = fplog_pkg::LNW'(e) * $signed({8'd0, fplog_pkg::Q_LN2});

  always_comb begin
    side_next.ten    = b_ten;
    side_next.spec   = b_spec;
    side_next.status = b_st;
    side_next.eln    = eln;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= 1'b0;
      b_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      a_vld   <= in_vld;
      b_vld   <= a_vld;
      out_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x   <= value;
      a_ten <= ten;
      if (value[WIDTH-1]) begin
        a_spec <= 1'b1;
        a_st   <= fplog_pkg::ST_DOMAIN;
      end else if (value == '0) begin
        a_spec <= 1'b1;
        a_st   <= fplog_pkg::ST_RANGE;
      end else begin
        a_spec <= (value == (WIDTH'(1) << FRAC_BITS));
        a_st   <= fplog_pkg::ST_OK;
      end
      b_x    <= a_x;
      b_ten  <= a_ten;
      b_spec <= a_spec;
      b_st   <= a_st;
      b_p    <= p_next;
      m      <= shifted[fplog_pkg::QB:0];
      side   <= side_next;
    end
  end

endmodule

[hdl/fplog_div.sv]
module fplog_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [fplog_pkg::QB:0]   m,
  input  fplog_pkg::side_t         in_side,
  output logic                     out_vld,
  output logic [fplog_pkg::QB-1:0] t,
  output fplog_pkg::side_t         out_side
);

  localparam int NS = fplog_pkg::DIV_STAGES;
  localparam int QB = fplog_pkg::QB;

  logic                  vld  [0:NS];
  logic [31:0]           rem  [0:NS];
  logic [31:0]           dvs  [0:NS];
  logic [QB-1:0]         quo  [0:NS];
  fplog_pkg::side_t      sd   [0:NS];

  // Numerator is (m-1) << 30 and m-1 < m+1, so the remainder starts at m-1.
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= 32'(m) - (32'd1 << QB);
      dvs[0] <= 32'(m) + (32'd1 << QB);
      quo[0] <= '0;
      sd[0]  <= in_side;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [31:0]                        r_n;
    logic [fplog_pkg::DIV_STEP-1:0]     q_n;

    always_comb begin
      logic [32:0] r2;
      r_n = rem[k];
      q_n = '0;
      for (int j = fplog_pkg::DIV_STEP - 1; j >= 0; j--) begin
        r2 = {r_n, 1'b0};
        if (r2 >= {1'b0, dvs[k]}) begin
          r2     = r2 - {1'b0, dvs[k]};
          q_n[j] = 1'b1;
        end
        r_n = r2[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= r_n;
        dvs[k+1] <= dvs[k];
        quo[k+1] <= {quo[k][QB-fplog_pkg::DIV_STEP-1:0], q_n};
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_vld  = vld[NS];
  assign t        = quo[NS];
  assign out_side = sd[NS];

endmodule

[hdl/fplog_series.sv]
module fplog_series #(
  parameter int WIDTH     = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [fplog_pkg::QB-1:0] t,
  input  fplog_pkg::side_t         in_side,
  output logic                     out_vld,
  output logic [WIDTH-1:0]         result,
  output logic [1:0]               status
);

  localparam int LNW = fplog_pkg::LNW;
  localparam int SH  = fplog_pkg::QB - FRAC_BITS;
  localparam int CW  = ((WIDTH > LNW + 1) ? WIDTH : LNW + 1) + 1;

  logic [7:0]            vld;
  fplog_pkg::side_t      sd [0:6];
  logic [LNW-1:0]        t1, t2, t3, t4, t2a, t2b, t2c;
  logic [LNW-1:0]        s1, s2, s3, r5, mag6, mag7;
  logic                  neg6, neg7;
  logic signed [LNW:0]   ln_sum;
  logic [CW-1:0]         rnd, pos_max, mag_sat;
  logic [WIDTH-1:0]      res_next;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[6:0], in_vld};
  end

  assign out_vld = vld[7];

  assign ln_sum = $signed({1'b0, r5}) + $signed({sd[4].eln[LNW-1], sd[4].eln});

  assign rnd = (CW'(mag7) + ((CW'(1) << SH) >> 1)) >> SH;
  assign pos_max = (CW'(1) << (WIDTH - 1)) - CW'(1);

  always_comb begin
    if (neg7) begin
      mag_sat  = (rnd > pos_max + CW'(1)) ? pos_max + CW'(1) : rnd;
      res_next = WIDTH'(CW'(0) - mag_sat);
    end else begin
      mag_sat  = (rnd > pos_max) ? pos_max : rnd;
      res_next = mag_sat[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // t squared.
      t1    <= LNW'(t);
      t2a   <= fplog_pkg::q30_rnd(72'(t) * 72'(t));
      sd[0] <= in_side;
      // Horner steps of the odd series.
      t2    <= t1;
      t2b   <= t2a;
      s1    <= LNW'(fplog_pkg::Q_TWO_5) + fplog_pkg::q30_rnd(72'(t2a) * 72'(fplog_pkg::Q_TWO_7));
      sd[1] <= sd[0];
      t3    <= t2;
      t2c   <= t2b;
      s2    <= LNW'(fplog_pkg::Q_TWO_3) + fplog_pkg::q30_rnd(72'(t2b) * 72'(s1));
      sd[2] <= sd[1];
      t4    <= t3;
      s3    <= LNW'(fplog_pkg::Q_TWO) + fplog_pkg::q30_rnd(72'(t2c) * 72'(s2));
      sd[3] <= sd[2];
      r5    <= fplog_pkg::q30_rnd(72'(t4) * 72'(s3));
      sd[4] <= sd[3];
      // Add the exponent term and split into sign and magnitude.
      neg6  <= ln_sum[LNW];
      mag6  <= ln_sum[LNW] ? LNW'(-ln_sum) : ln_sum[LNW-1:0];
      sd[5] <= sd[4];
      neg7  <= neg6;
      mag7  <= sd[5].ten ? fplog_pkg::q30_rnd(72'(mag6) * 72'(fplog_pkg::Q_LOG10E)) : mag6;
      sd[6] <= sd[5];
      if (sd[6].spec) begin
        result <= (sd[6].status == fplog_pkg::ST_OK) ? '0 : (WIDTH'(1) << (WIDTH - 1));
      end else begin
        result <= res_next;
      end
      status <= (sd[6].spec) ? sd[6].status : fplog_pkg::ST_OK;
    end
  end

endmodule

[hdl/fixed_point_natural_and_decimal_log_top.sv]
// Fixed-point natural and base-10 logarithm, signed Q(WIDTH-1-FRAC_BITS).FRAC_BITS.
// The pipeline runs normalization, then the radix-4 divider, then the series.
// Throughput is one word per cycle while the output is not stalled; a stalled output freezes the whole pipeline.
// Synchronous reset clears only the valid bits; data registers are not reset.
module fixed_point_natural_and_decimal_log_top #(
  parameter int WIDTH     = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  fplog_in_if.sink    din,
  fplog_out_if.source dout
);

  logic                     en;
  logic                     n_vld, d_vld;
  logic [fplog_pkg::QB:0]   m;
  logic [fplog_pkg::QB-1:0] t;
  fplog_pkg::side_t         n_side, d_side;

  assign en        = !dout.valid || dout.ready;
  assign din.ready = en;

  fplog_norm #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (din.valid),
    .value   (din.value),
    .ten     (din.base_ten),
    .out_vld (n_vld),
    .m       (m),
    .side    (n_side)
  );

  fplog_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (n_vld),
    .m        (m),
    .in_side  (n_side),
    .out_vld  (d_vld),
    .t        (t),
    .out_side (d_side)
  );

  fplog_series #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_series (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (d_vld),
    .t       (t),
    .in_side (d_side),
    .out_vld (dout.valid),
    .result  (dout.result),
    .status  (dout.status)
  );

endmodule
